>>> hdl/nll_pkg.sv
`default_nettype none

package nll_pkg;

  // field and datapath widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FB_W     = 15;
  localparam int unsigned GAIN_W   = 15;
  localparam int unsigned STAGE_W  = 32;
  localparam int unsigned DRV_W    = 17;  // tanh result, signed
  localparam int unsigned DIFF_W   = 18;  // difference of two tanh values
  localparam int unsigned ARG_W    = 34;  // feedback-corrected input, signed
  localparam int unsigned MULA_W   = 32;
  localparam int unsigned PROD_W   = MULA_W + DIFF_W;
  localparam int unsigned MAG_W    = PROD_W - 1;
  localparam int unsigned QMAG_W   = 33;
  localparam int unsigned QUO_W    = QMAG_W + 1;

  // cutoff / 3 as (cutoff * ceil(2^17 / 3)) >> 17, exact over 16 bits
  localparam logic signed [DIFF_W-1:0] RECIP_THIRD = 18'sd43691;
  localparam int unsigned               RECIP_SHIFT = 17;

  // 2^k - 1 divisors
  localparam logic [MAG_W-1:0] DEN_NARROW = MAG_W'(32767);
  localparam logic [MAG_W-1:0] DEN_WIDE   = MAG_W'(65535);

  localparam int unsigned TANH_ENTRIES = 256;

  localparam logic [15:0] TANH_ROM [TANH_ENTRIES] = '{
    16'h0000,16'h0266,16'h04CD,16'h0733,16'h0998,16'h0BFE,16'h0E62,16'h10C7,
    16'h132A,16'h158C,16'h17EE,16'h1A4E,16'h1CAE,16'h1F0C,16'h2168,16'h23C4,
    16'h261D,16'h2875,16'h2ACB,16'h2D20,16'h2F72,16'h31C2,16'h3410,16'h365C,
    16'h38A5,16'h3AED,16'h3D31,16'h3F73,16'h41B2,16'h43EF,16'h4629,16'h485F,
    16'h4A93,16'h4CC4,16'h4EF1,16'h511C,16'h5343,16'h5567,16'h5787,16'h59A4,
    16'h5BBD,16'h5DD3,16'h5FE5,16'h61F3,16'h63FE,16'h6604,16'h6807,16'h6A06,
    16'h6C01,16'h6DF8,16'h6FEB,16'h71DA,16'h73C5,16'h75AC,16'h778E,16'h796C,
    16'h7B46,16'h7D1C,16'h7EEE,16'h80BB,16'h8284,16'h8448,16'h8608,16'h87C4,
    16'h897C,16'h8B2F,16'h8CDD,16'h8E87,16'h902D,16'h91CE,16'h936B,16'h9504,
    16'h9698,16'h9827,16'h99B2,16'h9B39,16'h9CBB,16'h9E39,16'h9FB3,16'hA128,
    16'hA298,16'hA405,16'hA56D,16'hA6D1,16'hA830,16'hA98B,16'hAAE2,16'hAC34,
    16'hAD82,16'hAECC,16'hB012,16'hB154,16'hB292,16'hB3CB,16'hB500,16'hB631,
    16'hB75F,16'hB888,16'hB9AD,16'hBACE,16'hBBEB,16'hBD05,16'hBE1A,16'hBF2C,
    16'hC03A,16'hC144,16'hC24A,16'hC34D,16'hC44C,16'hC547,16'hC63F,16'hC733,
    16'hC824,16'hC911,16'hC9FA,16'hCAE1,16'hCBC3,16'hCCA3,16'hCD7F,16'hCE58,
    16'hCF2E,16'hD000,16'hD0CF,16'hD19B,16'hD264,16'hD32A,16'hD3ED,16'hD4AD,
    16'hD56A,16'hD623,16'hD6DB,16'hD78F,16'hD840,16'hD8EF,16'hD99B,16'hDA44,
    16'hDAEA,16'hDB8E,16'hDC2F,16'hDCCE,16'hDD6A,16'hDE03,16'hDE9A,16'hDF2F,
    16'hDFC1,16'hE051,16'hE0DE,16'hE16A,16'hE1F2,16'hE279,16'hE2FE,16'hE380,
    16'hE400,16'hE47E,16'hE4FA,16'hE574,16'hE5EB,16'hE661,16'hE6D5,16'hE747,
    16'hE7B7,16'hE825,16'hE891,16'hE8FC,16'hE964,16'hE9CB,16'hEA30,16'hEA93,
    16'hEAF5,16'hEB55,16'hEBB4,16'hEC10,16'hEC6B,16'hECC5,16'hED1D,16'hED74,
    16'hEDC9,16'hEE1C,16'hEE6E,16'hEEBF,16'hEF0E,16'hEF5C,16'hEFA9,16'hEFF4,
    16'hF03E,16'hF087,16'hF0CE,16'hF114,16'hF159,16'hF19D,16'hF1DF,16'hF221,
    16'hF261,16'hF2A0,16'hF2DE,16'hF31B,16'hF357,16'hF391,16'hF3CB,16'hF404,
    16'hF43B,16'hF472,16'hF4A8,16'hF4DD,16'hF510,16'hF543,16'hF575,16'hF5A6,
    16'hF5D7,16'hF606,16'hF634,16'hF662,16'hF68F,16'hF6BB,16'hF6E6,16'hF711,
    16'hF73B,16'hF764,16'hF78C,16'hF7B3,16'hF7DA,16'hF800,16'hF826,16'hF84A,
    16'hF86F,16'hF892,16'hF8B5,16'hF8D7,16'hF8F9,16'hF91A,16'hF93A,16'hF95A,
    16'hF979,16'hF997,16'hF9B6,16'hF9D3,16'hF9F0,16'hFA0D,16'hFA29,16'hFA44,
    16'hFA5F,16'hFA79,16'hFA93,16'hFAAD,16'hFAC6,16'hFADF,16'hFAF7,16'hFB0E,
    16'hFB26,16'hFB3C,16'hFB53,16'hFB69,16'hFB7F,16'hFB94,16'hFBA9,16'hFBFF
  };

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_FB_MUL,
    ST_FB_START,
    ST_FB_WAIT,
    ST_STG_MUL,
    ST_STG_START,
    ST_STG_WAIT,
    ST_DRIVE,
    ST_EMIT
  } nll_state_e;

  typedef enum logic [1:0] {
    STG_ONE,
    STG_TWO,
    STG_THREE,
    STG_FOUR
  } nll_stage_e;

  typedef enum logic [1:0] {
    MUL_CUTOFF,
    MUL_FEEDBACK,
    MUL_STAGE
  } nll_mul_e;

  typedef struct packed {
    logic       load_in;   // capture the input word
    logic       mul_en;    // load product register
    nll_mul_e   mul_sel;
    logic       gain_en;   // take cutoff / 3 from the product
    logic       div_start;
    logic       div_wide;  // divide by 65535, else 32767
    logic       fb_take;   // quotient is the feedback term
    logic       stg_take;  // quotient is a stage increment
    logic       drive_en;  // refresh the next stage's drive
    nll_stage_e stage;
    logic       emit;      // load the output register
  } nll_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;  // output word waiting and not taken this cycle
  } nll_sts_t;

  // tanh by table, index |v| >> 8 saturated, mirrored by sign
  function automatic logic signed [DRV_W-1:0] tanh_lookup(input logic signed [ARG_W-1:0] v);
    logic [ARG_W-1:0]         mag;
    logic [7:0]               idx;
    logic signed [DRV_W-1:0]  t;
    mag = v[ARG_W-1] ? $unsigned(-v) : $unsigned(v);
    idx = (|mag[ARG_W-1:16]) ? 8'hFF : mag[15:8];
    t   = $signed({1'b0, TANH_ROM[idx]});
    return (v > 0) ? t : -t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nll_cdiv.sv
`default_nettype none

// Truncating signed divide by 2^k - 1 (k = 15 or 16). Folds the magnitude
// as a = (a >> k) + (a mod 2^k), accumulating a >> k into the quotient,
// one fold per cycle, then a final correction when a equals the divisor.
module nll_cdiv (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic                                 wide_i,
  input  wire logic signed [nll_pkg::PROD_W-1:0]    num_i,
  output logic                                      done_o,
  output logic signed [nll_pkg::QUO_W-1:0]          quo_o
);
  import nll_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q;
  logic              wide_q;
  logic [MAG_W-1:0]  a_q, a_d;
  logic [QMAG_W-1:0] q_q, q_d;

  logic [MAG_W-1:0]  hi;
  logic [MAG_W-1:0]  lo;
  logic [MAG_W-1:0]  den;
  logic [PROD_W-1:0] num_mag;

  assign num_mag = num_i[PROD_W-1] ? $unsigned(-num_i) : $unsigned(num_i);

  // split the running remainder at bit k
  always_comb begin
    if (wide_q) begin
      hi  = a_q >> 16;
      lo  = {{(MAG_W-16){1'b0}}, a_q[15:0]};
      den = DEN_WIDE;
    end else begin
      hi  = a_q >> 15;
      lo  = {{(MAG_W-15){1'b0}}, a_q[14:0]};
      den = DEN_NARROW;
    end
  end

  // fold step and final correction
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = num_mag[MAG_W-1:0];
      q_d    = '0;
    end else if (busy_q) begin
      if (hi != '0) begin
        a_d = hi + lo;
        q_d = q_q + hi[QMAG_W-1:0];
      end else begin
        q_d    = q_q + {{(QMAG_W-1){1'b0}}, (a_q == den)};
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    q_q <= q_d;
    if (start_i) begin
      neg_q  <= num_i[PROD_W-1];
      wide_q <= wide_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

`default_nettype wire

>>> hdl/nll_datapath.sv
`default_nettype none

module nll_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [nll_pkg::FB_W-1:0]         cfg_feedback_amount_i,
  input  wire logic [nll_pkg::SAMPLE_W-1:0]     sample_in_i,
  input  wire logic [nll_pkg::SAMPLE_W-1:0]     cutoff_level_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [nll_pkg::SAMPLE_W-1:0]          sample_out_o,
  input  wire nll_pkg::nll_cmd_t                cmd_i,
  output nll_pkg::nll_sts_t                     sts_o
);
  import nll_pkg::*;

  // configuration and captured input word
  logic [FB_W-1:0]            fb_q;
  logic signed [SAMPLE_W-1:0] xb_q;
  logic [SAMPLE_W-1:0]        cutoff_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [ARG_W-1:0]    x_q;

  // filter state
  logic signed [STAGE_W-1:0]  s1_q, s2_q, s3_q, s4_q;
  logic signed [DRV_W-1:0]    d2_q, d3_q, d4_q;

  // shared multiplier
  logic signed [MULA_W-1:0]   mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   prod_q;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [DRV_W-1:0]    t_in;
  logic signed [DRV_W-1:0]    t_s4;

  logic                       div_done;
  logic signed [QUO_W-1:0]    quo;

  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= '0;
    end else if (cfg_valid_i) begin
      fb_q <= cfg_feedback_amount_i;
    end
  end

  // capture: offset binary to signed is a flip of the top bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xb_q     <= $signed(sample_in_i ^ 16'h8000);
      cutoff_q <= cutoff_level_i;
    end
    if (cmd_i.gain_en) begin
      gain_q <= prod_q[RECIP_SHIFT+GAIN_W-1:RECIP_SHIFT];
    end
    if (cmd_i.fb_take) begin
      x_q <= {{(ARG_W-SAMPLE_W){xb_q[SAMPLE_W-1]}}, xb_q} - quo;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  // stage input difference
  assign t_in = tanh_lookup(x_q);
  assign t_s4 = tanh_lookup({{(ARG_W-STAGE_W){s4_q[STAGE_W-1]}}, s4_q});

  always_comb begin
    unique case (cmd_i.stage)
      STG_ONE:   diff = DIFF_W'(t_in) - DIFF_W'(d2_q);
      STG_TWO:   diff = DIFF_W'(d2_q) - DIFF_W'(d3_q);
      STG_THREE: diff = DIFF_W'(d3_q) - DIFF_W'(d4_q);
      STG_FOUR:  diff = DIFF_W'(d4_q) - DIFF_W'(t_s4);
    endcase
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_CUTOFF: begin
        mul_a = $signed({{(MULA_W-SAMPLE_W){1'b0}}, cutoff_q});
        mul_b = RECIP_THIRD;
      end
      MUL_FEEDBACK: begin
        mul_a = s4_q;
        mul_b = $signed({{(DIFF_W-FB_W){1'b0}}, fb_q});
      end
      MUL_STAGE: begin
        mul_a = $signed({{(MULA_W-GAIN_W){1'b0}}, gain_q});
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  nll_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .wide_i  (cmd_i.div_wide),
    .num_i   (prod_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // integrators and drives, wrapping at 32 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      d2_q <= '0;
      d3_q <= '0;
      d4_q <= '0;
    end else begin
      if (cmd_i.stg_take) begin
        unique case (cmd_i.stage)
          STG_ONE:   s1_q <= s1_q + quo[STAGE_W-1:0];
          STG_TWO:   s2_q <= s2_q + quo[STAGE_W-1:0];
          STG_THREE: s3_q <= s3_q + quo[STAGE_W-1:0];
          STG_FOUR:  s4_q <= s4_q + quo[STAGE_W-1:0];
        endcase
      end
      if (cmd_i.drive_en) begin
        unique case (cmd_i.stage)
          STG_ONE:   d2_q <= tanh_lookup({{(ARG_W-STAGE_W){s1_q[STAGE_W-1]}}, s1_q});
          STG_TWO:   d3_q <= tanh_lookup({{(ARG_W-STAGE_W){s2_q[STAGE_W-1]}}, s2_q});
          STG_THREE: d4_q <= tanh_lookup({{(ARG_W-STAGE_W){s3_q[STAGE_W-1]}}, s3_q});
          STG_FOUR:  d4_q <= d4_q;
        endcase
      end
    end
  end

  // output register: back to offset binary
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= s4_q[SAMPLE_W-1:0] ^ 16'h8000;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_full  = out_valid_q & ~out_ready_i;

endmodule

`default_nettype wire

>>> hdl/nll_ctrl.sv
`default_nettype none

module nll_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output nll_pkg::nll_cmd_t       cmd_o,
  input  wire nll_pkg::nll_sts_t  sts_i
);
  import nll_pkg::*;

  nll_state_e state_q, state_d;
  nll_stage_e stage_q, stage_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_GAIN;
      ST_GAIN:      state_d = ST_FB_MUL;
      ST_FB_MUL:    state_d = ST_FB_START;
      ST_FB_START:  state_d = ST_FB_WAIT;
      ST_FB_WAIT:   if (sts_i.div_done) state_d = ST_STG_MUL;
      ST_STG_MUL:   state_d = ST_STG_START;
      ST_STG_START: state_d = ST_STG_WAIT;
      ST_STG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = (stage_q == STG_FOUR) ? ST_EMIT : ST_DRIVE;
        end
      end
      ST_DRIVE:     state_d = ST_STG_MUL;
      ST_EMIT:      if (!sts_i.out_full) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // stage pointer
  always_comb begin
    stage_d = stage_q;
    if (state_q == ST_FB_WAIT) begin
      stage_d = STG_ONE;
    end else if (state_q == ST_DRIVE) begin
      unique case (stage_q)
        STG_ONE:   stage_d = STG_TWO;
        STG_TWO:   stage_d = STG_THREE;
        STG_THREE: stage_d = STG_FOUR;
        STG_FOUR:  stage_d = STG_FOUR;
      endcase
    end
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_STAGE;
    cmd_o.stage     = stage_q;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_GAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CUTOFF;
      end
      ST_FB_MUL: begin
        cmd_o.gain_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FEEDBACK;
      end
      ST_FB_START: begin
        cmd_o.div_start = 1'b1;
      end
      ST_FB_WAIT: begin
        cmd_o.fb_take = sts_i.div_done;
      end
      ST_STG_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      ST_STG_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_wide  = 1'b1;
      end
      ST_STG_WAIT: begin
        cmd_o.stg_take = sts_i.div_done;
      end
      ST_DRIVE: begin
        cmd_o.drive_en = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = ~sts_i.out_full;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= STG_ONE;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nonlinear_ladder_lowpass_core.sv
// One word at a time; each divide folds up to four times for the feedback term
// and up to two times per stage, then finishes and hands off its quotient.
// The next word can be taken in the cycle after the result is loaded; a waiting
// output word adds its stall.
// Reset (rst_ni low, asynchronous) clears the integrators, drives, feedback amount,
// controller state and output valid.
`default_nettype none

module nonlinear_ladder_lowpass_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [nll_pkg::FB_W-1:0]      cfg_feedback_amount_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [nll_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  wire logic [nll_pkg::SAMPLE_W-1:0]  cutoff_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [nll_pkg::SAMPLE_W-1:0]       sample_out_o
);
  import nll_pkg::*;

  nll_cmd_t cmd;
  nll_sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  nll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  nll_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_feedback_amount_i (cfg_feedback_amount_i),
    .sample_in_i           (sample_in_i),
    .cutoff_level_i        (cutoff_level_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .sample_out_o          (sample_out_o),
    .cmd_i                 (cmd),
    .sts_o                 (sts)
  );

endmodule

`default_nettype wire

>>> dv/tb_nonlinear_ladder_lowpass_core.sv
module tb_nonlinear_ladder_lowpass_core;

  localparam int unsigned SMP_W         = nll_pkg::SAMPLE_W;
  localparam int unsigned GAIN_W        = nll_pkg::FB_W;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned PHASE_WORDS   = 250;
  localparam logic [GAIN_W-1:0] FB_UNITY = 15'd32767;

  // tanh table, index |v| >> 8, last entry doubles as saturation value
  localparam logic [15:0] TANH_WORDS [256] = '{
    16'h0000,16'h0266,16'h04CD,16'h0733,16'h0998,16'h0BFE,16'h0E62,16'h10C7,
    16'h132A,16'h158C,16'h17EE,16'h1A4E,16'h1CAE,16'h1F0C,16'h2168,16'h23C4,
    16'h261D,16'h2875,16'h2ACB,16'h2D20,16'h2F72,16'h31C2,16'h3410,16'h365C,
    16'h38A5,16'h3AED,16'h3D31,16'h3F73,16'h41B2,16'h43EF,16'h4629,16'h485F,
    16'h4A93,16'h4CC4,16'h4EF1,16'h511C,16'h5343,16'h5567,16'h5787,16'h59A4,
    16'h5BBD,16'h5DD3,16'h5FE5,16'h61F3,16'h63FE,16'h6604,16'h6807,16'h6A06,
    16'h6C01,16'h6DF8,16'h6FEB,16'h71DA,16'h73C5,16'h75AC,16'h778E,16'h796C,
    16'h7B46,16'h7D1C,16'h7EEE,16'h80BB,16'h8284,16'h8448,16'h8608,16'h87C4,
    16'h897C,16'h8B2F,16'h8CDD,16'h8E87,16'h902D,16'h91CE,16'h936B,16'h9504,
    16'h9698,16'h9827,16'h99B2,16'h9B39,16'h9CBB,16'h9E39,16'h9FB3,16'hA128,
    16'hA298,16'hA405,16'hA56D,16'hA6D1,16'hA830,16'hA98B,16'hAAE2,16'hAC34,
    16'hAD82,16'hAECC,16'hB012,16'hB154,16'hB292,16'hB3CB,16'hB500,16'hB631,
    16'hB75F,16'hB888,16'hB9AD,16'hBACE,16'hBBEB,16'hBD05,16'hBE1A,16'hBF2C,
    16'hC03A,16'hC144,16'hC24A,16'hC34D,16'hC44C,16'hC547,16'hC63F,16'hC733,
    16'hC824,16'hC911,16'hC9FA,16'hCAE1,16'hCBC3,16'hCCA3,16'hCD7F,16'hCE58,
    16'hCF2E,16'hD000,16'hD0CF,16'hD19B,16'hD264,16'hD32A,16'hD3ED,16'hD4AD,
    16'hD56A,16'hD623,16'hD6DB,16'hD78F,16'hD840,16'hD8EF,16'hD99B,16'hDA44,
    16'hDAEA,16'hDB8E,16'hDC2F,16'hDCCE,16'hDD6A,16'hDE03,16'hDE9A,16'hDF2F,
    16'hDFC1,16'hE051,16'hE0DE,16'hE16A,16'hE1F2,16'hE279,16'hE2FE,16'hE380,
    16'hE400,16'hE47E,16'hE4FA,16'hE574,16'hE5EB,16'hE661,16'hE6D5,16'hE747,
    16'hE7B7,16'hE825,16'hE891,16'hE8FC,16'hE964,16'hE9CB,16'hEA30,16'hEA93,
    16'hEAF5,16'hEB55,16'hEBB4,16'hEC10,16'hEC6B,16'hECC5,16'hED1D,16'hED74,
    16'hEDC9,16'hEE1C,16'hEE6E,16'hEEBF,16'hEF0E,16'hEF5C,16'hEFA9,16'hEFF4,
    16'hF03E,16'hF087,16'hF0CE,16'hF114,16'hF159,16'hF19D,16'hF1DF,16'hF221,
    16'hF261,16'hF2A0,16'hF2DE,16'hF31B,16'hF357,16'hF391,16'hF3CB,16'hF404,
    16'hF43B,16'hF472,16'hF4A8,16'hF4DD,16'hF510,16'hF543,16'hF575,16'hF5A6,
    16'hF5D7,16'hF606,16'hF634,16'hF662,16'hF68F,16'hF6BB,16'hF6E6,16'hF711,
    16'hF73B,16'hF764,16'hF78C,16'hF7B3,16'hF7DA,16'hF800,16'hF826,16'hF84A,
    16'hF86F,16'hF892,16'hF8B5,16'hF8D7,16'hF8F9,16'hF91A,16'hF93A,16'hF95A,
    16'hF979,16'hF997,16'hF9B6,16'hF9D3,16'hF9F0,16'hFA0D,16'hFA29,16'hFA44,
    16'hFA5F,16'hFA79,16'hFA93,16'hFAAD,16'hFAC6,16'hFADF,16'hFAF7,16'hFB0E,
    16'hFB26,16'hFB3C,16'hFB53,16'hFB69,16'hFB7F,16'hFB94,16'hFBA9,16'hFBFF
  };

  // DUT inputs, known from time zero
  logic              clk_i                 = 1'b0;
  logic              rst_ni                = 1'b0;
  logic              cfg_valid_i           = 1'b0;
  logic [GAIN_W-1:0] cfg_feedback_amount_i = '0;
  logic              in_valid_i            = 1'b0;
  logic [SMP_W-1:0]  sample_in_i           = '0;
  logic [SMP_W-1:0]  cutoff_level_i        = '0;
  logic              out_ready_i           = 1'b0;

  logic              cfg_ready_o;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [SMP_W-1:0]  sample_out_o;

  // filter state as the predictor sees it
  logic [GAIN_W-1:0]  fb_gain;
  logic signed [31:0] pole1, pole2, pole3, pole4;
  logic signed [31:0] drive2, drive3, drive4;

  logic [SMP_W-1:0] expected_out [$];

  // run bookkeeping
  bit          no_idle;
  int unsigned sink_hold;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned cfg_writes;
  int unsigned table_sat_hits;

  nonlinear_ladder_lowpass_core DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_feedback_amount_i(cfg_feedback_amount_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .sample_in_i          (sample_in_i),
    .cutoff_level_i       (cutoff_level_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .sample_out_o         (sample_out_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // tanh by table, mirrored by sign; zero and negative both take the minus side
  function automatic longint tanh_of(input longint v);
    longint mag;
    longint idx;
    longint t;
    mag = (v < 0) ? -v : v;
    idx = mag >> 8;
    if (idx > 255) begin
      idx = 255;
      table_sat_hits++;
    end
    t = longint'(TANH_WORDS[idx]);
    return (v > 0) ? t : -t;
  endfunction

  // one-pole step, truncating divide, wraps to the 32-bit register
  function automatic logic signed [31:0] integrate(input logic signed [31:0] y,
                                                   input longint g, input longint d);
    longint sum;
    sum = longint'(y) + (g * d) / 65535;
    return sum[31:0];
  endfunction

  // advance the ladder by one sample and return the expected output word
  function automatic logic [SMP_W-1:0] ladder_step(input logic [SMP_W-1:0] smp,
                                                   input logic [SMP_W-1:0] cut);
    longint x;
    longint g;
    longint old4;
    longint t;
    x    = longint'(smp) - 32768;
    g    = longint'(cut) / 3;
    old4 = longint'(pole4);
    x    = x - (longint'(fb_gain) * old4) / 32767;

    pole1  = integrate(pole1, g, tanh_of(x) - longint'(drive2));
    t      = tanh_of(longint'(pole1));
    drive2 = t[31:0];

    pole2  = integrate(pole2, g, longint'(drive2) - longint'(drive3));
    t      = tanh_of(longint'(pole2));
    drive3 = t[31:0];

    pole3  = integrate(pole3, g, longint'(drive3) - longint'(drive4));
    t      = tanh_of(longint'(pole3));
    drive4 = t[31:0];

    pole4  = integrate(pole4, g, longint'(drive4) - tanh_of(old4));
    return pole4[15:0] + 16'd32768;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // present one input word; valid stays high afterwards until the next call
  task automatic send_sample(input logic [SMP_W-1:0] smp, input logic [SMP_W-1:0] cut);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_in_i    <= smp;
    cutoff_level_i <= cut;
    do @(posedge clk_i); while (!in_ready_o);
    expected_out.push_back(ladder_step(smp, cut));
    words_sent++;
  endtask

  // stop sending and let every outstanding word come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_feedback(input logic [GAIN_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_feedback_amount_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    fb_gain = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output stall: hold ready low for a drawn number of cycles while a word waits
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        out_ready_i <= 1'b0;
        if (out_valid_o) sink_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : output_check
    logic [SMP_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      sink_hold = no_idle ? 0 : $urandom_range(0, 7);
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected output word %h", $realtime, sample_out_o);
      end else begin
        want = expected_out.pop_front();
        words_checked++;
        if (sample_out_o !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] sample_out word %0d: expected %h, got %h",
                     $realtime, words_checked, want, sample_out_o);
        end
      end
    end
  end

  // watchdog: ends the run after a long stretch with no handshake anywhere
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d words outstanding",
             QUIET_LIMIT, expected_out.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset gain, silent and near-silent input: table lookups at the zero entry
  task automatic test_zero_input();
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h8000, 16'hFFFF);
    send_sample(16'h8001, 16'hFFFF);
  endtask

  // corner values of both fields with no feedback
  task automatic test_field_extremes();
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0000, 16'h0002);
    send_sample(16'hFFFF, 16'h0003);
    send_sample(16'h7FFF, 16'hFFFE);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h8000);
  endtask

  // unity resonance with a full-scale square wave drives lookups past the table end
  task automatic test_full_resonance();
    int i;
    wait_drained();
    write_feedback(FB_UNITY);
    for (i = 0; i < 10; i++)
      send_sample((i % 4 < 2) ? 16'h0000 : 16'hFFFF, 16'hFFFF);
  endtask

  // random runs of held levels with noise, over several feedback settings
  task automatic test_random_settings();
    logic [GAIN_W-1:0] settings [6];
    int unsigned       run_left;
    logic [SMP_W-1:0]  run_level;
    logic [SMP_W-1:0]  run_cut;
    logic [SMP_W-1:0]  smp;
    logic [SMP_W-1:0]  cut;
    int                p;
    int                i;
    settings = '{15'd0, FB_UNITY, 15'd1, 15'd16384, 15'd0, 15'd0};
    settings[4] = GAIN_W'($urandom_range(0, 32767));
    settings[5] = GAIN_W'($urandom_range(24000, 32767));
    for (p = 0; p < 6; p++) begin
      wait_drained();
      write_feedback(settings[p]);
      run_left = 0;
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 63) == 0) wait_drained();
        if (run_left == 0) begin
          run_left = $urandom_range(1, 16);
          case ($urandom_range(0, 5))
            0:       run_level = 16'h0000;
            1:       run_level = 16'hFFFF;
            2:       run_level = 16'h8000;
            default: run_level = SMP_W'($urandom);
          endcase
          case ($urandom_range(0, 5))
            0:       run_cut = 16'hFFFF;
            1:       run_cut = SMP_W'($urandom_range(0, 2));
            2:       run_cut = SMP_W'($urandom_range(0, 3000));
            default: run_cut = SMP_W'($urandom);
          endcase
        end
        run_left--;
        smp = ($urandom_range(0, 3) == 0) ? SMP_W'($urandom) : run_level;
        cut = ($urandom_range(0, 7) == 0) ? SMP_W'($urandom) : run_cut;
        send_sample(smp, cut);
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    fb_gain   = '0;
    pole1     = '0;
    pole2     = '0;
    pole3     = '0;
    pole4     = '0;
    drive2    = '0;
    drive3    = '0;
    drive4    = '0;
    no_idle   = 1'b0;
    sink_hold = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_input();
    test_field_extremes();
    test_full_resonance();
    test_random_settings();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("%0d samples through %0d feedback writes, %0d output words checked",
             words_sent, cfg_writes, words_checked);
    $display("%0d table lookups saturated at the last entry, %0d mismatches",
             table_sat_hits, mismatches);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/nll_pkg.sv
hdl/nll_cdiv.sv
hdl/nll_datapath.sv
hdl/nll_ctrl.sv
hdl/nonlinear_ladder_lowpass_core.sv
dv/tb_nonlinear_ladder_lowpass_core.sv
